FILE: rtl/core/ws2812_pixel_string_driver_core_macros.svh
// assertion macros for the pixel string driver checker
// expects clk and rst_n to be visible where the macros are used
`ifndef WS2812_PIXEL_STRING_DRIVER_CORE_MACROS_SVH
`define WS2812_PIXEL_STRING_DRIVER_CORE_MACROS_SVH

// condition and consequence in the same cycle
`define WSPSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel string driver check failed");

// consequence in the cycle after the condition
`define WSPSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel string driver check failed");

`endif

FILE: rtl/core/wspsd_pkg.sv
// shared constants, codes and types of the pixel string driver
// no dependencies
package wspsd_pkg;

    localparam int MAX_PIXELS_DEF = 64;

    localparam int PIX_W      = 24;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int COLOR_W    = 8;
    localparam int PULSE_W    = 10;
    localparam int LATCH_W    = 16;
    localparam int HOLD_W     = 24;
    localparam int COUNT_W    = 7;
    localparam int BIT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [PIX_W-1:0] PIXEL_RESET = 24'h010000;
    localparam logic [BIT_W-1:0] MSB_BIT     = 5'd23;

    localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 10'd140;
    localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 10'd120;
    localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 10'd70;
    localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 10'd160;
    localparam logic [LATCH_W-1:0] LATCH_RST     = 16'd10200;
    localparam logic [HOLD_W-1:0]  HOLDOFF_RST   = 24'd4000000;
    localparam logic [COUNT_W-1:0] ACTIVE_RST    = 7'd42;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd6;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_HIGH  = 5'b00010,
        PH_LOW   = 5'b00100,
        PH_LATCH = 5'b01000,
        PH_HOLD  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic line;
        logic busy;
        logic ok;
    } result_t;

endpackage

FILE: rtl/core/wspsd_pixel_mem.sv
// pixel word memory: one write port, one registered read port
// sweeps every entry to the reset word after reset; uses wspsd_pkg
module wspsd_pixel_mem #(
    parameter int MAX_PIXELS = wspsd_pkg::MAX_PIXELS_DEF,
    parameter int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [wspsd_pkg::PIX_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [wspsd_pkg::PIX_W-1:0]  rd_data,
    output logic                         clearing
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

    logic [wspsd_pkg::PIX_W-1:0] mem [MAX_PIXELS];
    logic [wspsd_pkg::PIX_W-1:0] rd_data_reg;
    logic                        clr_active_reg;
    logic                        clr_active_next;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic [ADDR_W-1:0]           clr_addr_next;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= wspsd_pkg::PIXEL_RESET;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

endmodule

FILE: rtl/core/ws2812_pixel_string_driver_core.sv
// serial pixel string driver: pixel memory, waveform sequencer, result buffer
// uses wspsd_pkg and wspsd_pixel_mem
//
// One command item is taken per clock while in_ready is high and gives
// one result item; a tick advances the line waveform by one time unit.
// Pixel words live in a synchronous memory whose word is fetched when a
// pixel's first high pulse starts, so its length is known from the next
// tick on. After reset the memory is swept to the reset word, during
// which in_ready stays low; configuration writes are taken at any time.
// Results pass through a two-entry output buffer, so in_ready does not
// depend on out_ready and one item per clock is sustained while results
// are taken every cycle.
module ws2812_pixel_string_driver_core #(
    parameter int MAX_PIXELS = wspsd_pkg::MAX_PIXELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [wspsd_pkg::CMD_W-1:0]        command,
    input  logic [wspsd_pkg::IDX_W-1:0]        pixel_index,
    input  logic [wspsd_pkg::COLOR_W-1:0]      red,
    input  logic [wspsd_pkg::COLOR_W-1:0]      green,
    input  logic [wspsd_pkg::COLOR_W-1:0]      blue,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               line_level,
    output logic                               busy_res,
    output logic                               accepted,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wspsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wspsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int MAXP_W  = 11;
    localparam logic [MAXP_W-1:0] MAX_P = MAXP_W'(MAX_PIXELS);

    // configuration
    logic [wspsd_pkg::PULSE_W-1:0] one_high_reg;
    logic [wspsd_pkg::PULSE_W-1:0] one_low_reg;
    logic [wspsd_pkg::PULSE_W-1:0] zero_high_reg;
    logic [wspsd_pkg::PULSE_W-1:0] zero_low_reg;
    logic [wspsd_pkg::LATCH_W-1:0] latch_reg;
    logic [wspsd_pkg::HOLD_W-1:0]  holdoff_reg;
    logic [wspsd_pkg::COUNT_W-1:0] active_reg;

    // sequencer
    wspsd_pkg::phase_t             phase_reg;
    wspsd_pkg::phase_t             phase_next;
    logic [wspsd_pkg::HOLD_W-1:0]  elapsed_reg;
    logic [wspsd_pkg::HOLD_W-1:0]  elapsed_next;
    logic [wspsd_pkg::BIT_W-1:0]   bit_ptr_reg;
    logic [wspsd_pkg::BIT_W-1:0]   bit_ptr_next;
    logic [wspsd_pkg::COUNT_W-1:0] pix_ptr_reg;
    logic [wspsd_pkg::COUNT_W-1:0] pix_ptr_next;
    logic [wspsd_pkg::COUNT_W-1:0] pix_inc;
    logic [wspsd_pkg::COUNT_W-1:0] eff_count;
    logic [wspsd_pkg::HOLD_W-1:0]  raw_len;
    logic [wspsd_pkg::HOLD_W-1:0]  phase_len;
    logic [wspsd_pkg::HOLD_W:0]    elapsed_inc;
    logic                          phase_done;
    logic                          busy;
    logic                          cur_bit;
    logic                          ok;

    // memory port
    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    logic [wspsd_pkg::PIX_W-1:0]   mem_wr_data;
    logic                          mem_rd_en;
    logic [ADDR_W-1:0]             mem_rd_addr;
    logic [wspsd_pkg::PIX_W-1:0]   mem_rd_data;
    logic                          mem_clearing;

    // result buffer
    wspsd_pkg::result_t            res_new;
    wspsd_pkg::result_t            out_reg;
    wspsd_pkg::result_t            skid_reg;
    logic                          out_valid_reg;
    logic                          skid_valid_reg;
    logic                          in_fire;
    logic                          out_fire;
    logic                          cfg_fire;

    assign in_ready  = !skid_valid_reg && !mem_clearing;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    wspsd_pixel_mem #(
        .MAX_PIXELS (MAX_PIXELS),
        .ADDR_W     (ADDR_W)
    ) u_pixel_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .clearing (mem_clearing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= wspsd_pkg::ONE_HIGH_RST;
            one_low_reg   <= wspsd_pkg::ONE_LOW_RST;
            zero_high_reg <= wspsd_pkg::ZERO_HIGH_RST;
            zero_low_reg  <= wspsd_pkg::ZERO_LOW_RST;
            latch_reg     <= wspsd_pkg::LATCH_RST;
            holdoff_reg   <= wspsd_pkg::HOLDOFF_RST;
            active_reg    <= wspsd_pkg::ACTIVE_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                wspsd_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_data[wspsd_pkg::PULSE_W-1:0];
                wspsd_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_data[wspsd_pkg::PULSE_W-1:0];
                wspsd_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_data[wspsd_pkg::PULSE_W-1:0];
                wspsd_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_data[wspsd_pkg::PULSE_W-1:0];
                wspsd_pkg::REG_LATCH:     latch_reg     <= cfg_data[wspsd_pkg::LATCH_W-1:0];
                wspsd_pkg::REG_HOLDOFF:   holdoff_reg   <= cfg_data[wspsd_pkg::HOLD_W-1:0];
                wspsd_pkg::REG_ACTIVE:    active_reg    <= cfg_data[wspsd_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pixel count limited to the memory depth
    assign eff_count = (MAXP_W'(active_reg) > MAX_P) ? MAX_P[wspsd_pkg::COUNT_W-1:0]
                                                      : active_reg;
    assign busy      = (phase_reg != wspsd_pkg::PH_IDLE);
    assign cur_bit   = mem_rd_data[bit_ptr_reg];
    assign pix_inc   = pix_ptr_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            wspsd_pkg::PH_HIGH:
                raw_len = cur_bit ? wspsd_pkg::HOLD_W'(one_high_reg)
                                  : wspsd_pkg::HOLD_W'(zero_high_reg);
            wspsd_pkg::PH_LOW:
                raw_len = cur_bit ? wspsd_pkg::HOLD_W'(one_low_reg)
                                  : wspsd_pkg::HOLD_W'(zero_low_reg);
            wspsd_pkg::PH_LATCH:
                raw_len = wspsd_pkg::HOLD_W'(latch_reg);
            wspsd_pkg::PH_HOLD:
                raw_len = holdoff_reg;
            default:
                raw_len = '0;
        endcase
    end

    assign phase_len   = (raw_len == '0) ? wspsd_pkg::HOLD_W'(1) : raw_len;
    assign elapsed_inc = {1'b0, elapsed_reg} + 1'b1;
    assign phase_done  = (elapsed_inc >= {1'b0, phase_len});

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        bit_ptr_next = bit_ptr_reg;
        pix_ptr_next = pix_ptr_reg;
        ok           = 1'b1;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = ADDR_W'(pixel_index);
        mem_wr_data  = {green, red, blue};
        mem_rd_en    = 1'b0;
        mem_rd_addr  = ADDR_W'(pix_inc);
        if (in_fire)
        begin
            unique case (command)
                wspsd_pkg::CMD_TICK:
                begin
                    if (busy)
                    begin
                        if (phase_done)
                        begin
                            elapsed_next = '0;
                            unique case (phase_reg)
                                wspsd_pkg::PH_HIGH:
                                begin
                                    phase_next = wspsd_pkg::PH_LOW;
                                end
                                wspsd_pkg::PH_LOW:
                                begin
                                    if (bit_ptr_reg != '0)
                                    begin
                                        bit_ptr_next = bit_ptr_reg - 1'b1;
                                        phase_next   = wspsd_pkg::PH_HIGH;
                                    end
                                    else if (pix_inc < eff_count)
                                    begin
                                        // fetch next pixel word
                                        pix_ptr_next = pix_inc;
                                        bit_ptr_next = wspsd_pkg::MSB_BIT;
                                        phase_next   = wspsd_pkg::PH_HIGH;
                                        mem_rd_en    = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = wspsd_pkg::PH_LATCH;
                                    end
                                end
                                wspsd_pkg::PH_LATCH:
                                begin
                                    phase_next = (holdoff_reg != '0) ? wspsd_pkg::PH_HOLD
                                                                     : wspsd_pkg::PH_IDLE;
                                end
                                default:
                                begin
                                    phase_next = wspsd_pkg::PH_IDLE;
                                end
                            endcase
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc[wspsd_pkg::HOLD_W-1:0];
                        end
                    end
                end
                wspsd_pkg::CMD_SET:
                begin
                    if (busy)
                    begin
                        ok = 1'b0;
                    end
                    else if ({1'b0, pixel_index} < eff_count)
                    begin
                        mem_wr_en = 1'b1;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                wspsd_pkg::CMD_FLUSH:
                begin
                    if (busy)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        if (eff_count == '0)
                        begin
                            phase_next = wspsd_pkg::PH_LATCH;
                        end
                        else
                        begin
                            pix_ptr_next = '0;
                            bit_ptr_next = wspsd_pkg::MSB_BIT;
                            phase_next   = wspsd_pkg::PH_HIGH;
                            mem_rd_en    = 1'b1;
                            mem_rd_addr  = '0;
                        end
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= wspsd_pkg::PH_IDLE;
            elapsed_reg <= '0;
            bit_ptr_reg <= '0;
            pix_ptr_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            bit_ptr_reg <= bit_ptr_next;
            pix_ptr_reg <= pix_ptr_next;
        end
    end

    assign res_new.line = (phase_next == wspsd_pkg::PH_HIGH);
    assign res_new.busy = (phase_next != wspsd_pkg::PH_IDLE);
    assign res_new.ok   = ok;

    // two-entry result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= res_new;
            end
            else
            begin
                out_reg <= res_new;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = out_reg.line;
    assign busy_res   = out_reg.busy;
    assign accepted   = out_reg.ok;

endmodule

FILE: rtl/core/wspsd_checker.sv
// port-level checks for the pixel string driver core
// uses ws2812_pixel_string_driver_core_macros.svh; bound to the top level below
`include "ws2812_pixel_string_driver_core_macros.svh"

module wspsd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic line_level,
    input logic busy_res,
    input logic accepted
);

    // a stalled result holds
    `WSPSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(line_level) && $stable(busy_res) && $stable(accepted))

    // the line is only high while a transfer of pixels is running
    `WSPSD_ASSERT_SAME(a_line_busy, out_valid && line_level, busy_res)

    // input backpressure after reset only comes from a full result buffer
    `WSPSD_ASSERT_SAME(a_ready_drop, $fell(in_ready), out_valid)

endmodule

bind ws2812_pixel_string_driver_core wspsd_checker u_wspsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_level (line_level),
    .busy_res   (busy_res),
    .accepted   (accepted)
);

FILE: tb/ws2812_pixel_string_checker.sv
`timescale 1ns / 1ps
// result checker for the pixel string driver: watches the command, result and register channels
// keeps its own pixel store and waveform sequencer and compares every result transfer
// depends on wspsd_pkg
module ws2812_pixel_string_checker #(
    parameter int MAX_PIXELS = wspsd_pkg::MAX_PIXELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [wspsd_pkg::CMD_W-1:0]      command,
    input  logic [wspsd_pkg::IDX_W-1:0]      pixel_index,
    input  logic [wspsd_pkg::COLOR_W-1:0]    red,
    input  logic [wspsd_pkg::COLOR_W-1:0]    green,
    input  logic [wspsd_pkg::COLOR_W-1:0]    blue,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             line_level,
    input  logic                             busy_res,
    input  logic                             accepted,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [wspsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wspsd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                      fail_count,
    output int unsigned                      pending,
    output int unsigned                      checked,
    output logic                             string_busy
);
    import wspsd_pkg::*;

    localparam int MAX_REPORTS = 30;

    logic [PIX_W-1:0]   pixel_mem [MAX_PIXELS];
    phase_t             seq_phase;
    int unsigned        pix_ptr;
    logic [BIT_W-1:0]   bit_ptr;
    logic [HOLD_W-1:0]  ticks_left;
    logic [PIX_W-1:0]   shift_reg;

    logic [PULSE_W-1:0] one_hi_len;
    logic [PULSE_W-1:0] one_lo_len;
    logic [PULSE_W-1:0] zero_hi_len;
    logic [PULSE_W-1:0] zero_lo_len;
    logic [LATCH_W-1:0] latch_len;
    logic [HOLD_W-1:0]  hold_len;
    logic [COUNT_W-1:0] active_cnt;

    result_t            expected_q [$];
    int unsigned        report_cnt;

    function automatic logic [HOLD_W-1:0] at_least_one(input logic [HOLD_W-1:0] v);
        return (v == '0) ? 1 : v;
    endfunction

    function automatic int unsigned pixel_count();
        return (active_cnt > MAX_PIXELS) ? MAX_PIXELS : active_cnt;
    endfunction

    task automatic start_high();
        seq_phase  = PH_HIGH;
        ticks_left = at_least_one(shift_reg[bit_ptr] ? one_hi_len : zero_hi_len);
    endtask

    task automatic load_pixel(input int unsigned p);
        pix_ptr   = p;
        shift_reg = pixel_mem[p % MAX_PIXELS];
        bit_ptr   = MSB_BIT;
        start_high();
    endtask

    task automatic start_latch();
        seq_phase  = PH_LATCH;
        ticks_left = at_least_one(latch_len);
    endtask

    task automatic advance_wave();
        if (seq_phase != PH_IDLE) begin
            if (ticks_left > 1) begin
                ticks_left = ticks_left - 1;
            end
            else begin
                ticks_left = '0;
                case (seq_phase)
                    PH_HIGH:
                    begin
                        seq_phase  = PH_LOW;
                        ticks_left = at_least_one(shift_reg[bit_ptr] ? one_lo_len : zero_lo_len);
                    end
                    PH_LOW:
                    begin
                        if (bit_ptr != 0) begin
                            bit_ptr = bit_ptr - 1;
                            start_high();
                        end
                        else if (pix_ptr + 1 < pixel_count()) begin
                            load_pixel(pix_ptr + 1);
                        end
                        else begin
                            start_latch();
                        end
                    end
                    PH_LATCH:
                    begin
                        if (hold_len != '0) begin
                            seq_phase  = PH_HOLD;
                            ticks_left = hold_len;
                        end
                        else begin
                            seq_phase = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        seq_phase = PH_IDLE;
                    end
                endcase
            end
        end
    endtask

    task automatic predict_result(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                                  input logic [COLOR_W-1:0] b, output result_t res);
        logic ok;
        ok = 1'b1;
        if (cmd == CMD_TICK) begin
            advance_wave();
        end
        else if (seq_phase != PH_IDLE || !(cmd == CMD_SET || cmd == CMD_FLUSH)) begin
            ok = 1'b0;
        end
        else if (cmd == CMD_SET) begin
            if (idx < pixel_count())
                pixel_mem[idx % MAX_PIXELS] = {g, r, b};
            else
                ok = 1'b0;
        end
        else if (pixel_count() == 0) begin
            start_latch();
        end
        else begin
            load_pixel(0);
        end
        res.line = (seq_phase == PH_HIGH);
        res.busy = (seq_phase != PH_IDLE);
        res.ok   = ok;
    endtask

    task automatic check_bit(input string what, input logic want_v, input logic got_v,
                             inout int unsigned errs);
        if (want_v !== got_v) begin
            errs++;
            if (report_cnt < MAX_REPORTS)
                $display("%0t: %s expected %b got %b", $time, what, want_v, got_v);
            report_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        result_t     got;
        result_t     want;
        result_t     res;
        int unsigned errs;
        if (!rst_n) begin
            for (int i = 0; i < MAX_PIXELS; i++)
                pixel_mem[i] = PIXEL_RESET;
            seq_phase   = PH_IDLE;
            pix_ptr     = 0;
            bit_ptr     = '0;
            ticks_left  = '0;
            shift_reg   = '0;
            one_hi_len  = ONE_HIGH_RST;
            one_lo_len  = ONE_LOW_RST;
            zero_hi_len = ZERO_HIGH_RST;
            zero_lo_len = ZERO_LOW_RST;
            latch_len   = LATCH_RST;
            hold_len    = HOLDOFF_RST;
            active_cnt  = ACTIVE_RST;
            expected_q.delete();
            report_cnt  = 0;
            fail_count  <= 0;
            pending     <= 0;
            checked     <= 0;
            string_busy <= 1'b0;
        end
        else begin
            errs = 0;
            // result transfer against the oldest expectation
            if (out_valid && out_ready) begin
                got = {line_level, busy_res, accepted};
                if (expected_q.size() == 0) begin
                    errs++;
                    if (report_cnt < MAX_REPORTS)
                        $display("%0t: result with none expected: line %b busy %b accepted %b",
                                 $time, got.line, got.busy, got.ok);
                    report_cnt++;
                end
                else begin
                    want = expected_q.pop_front();
                    check_bit("line_level", want.line, got.line, errs);
                    check_bit("busy_res", want.busy, got.busy, errs);
                    check_bit("accepted", want.ok, got.ok, errs);
                end
                checked <= checked + 1;
            end
            if (in_valid && in_ready) begin
                predict_result(command, pixel_index, red, green, blue, res);
                expected_q.push_back(res);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ONE_HIGH:  one_hi_len  = cfg_data[PULSE_W-1:0];
                    REG_ONE_LOW:   one_lo_len  = cfg_data[PULSE_W-1:0];
                    REG_ZERO_HIGH: zero_hi_len = cfg_data[PULSE_W-1:0];
                    REG_ZERO_LOW:  zero_lo_len = cfg_data[PULSE_W-1:0];
                    REG_LATCH:     latch_len   = cfg_data[LATCH_W-1:0];
                    REG_HOLDOFF:   hold_len    = cfg_data[HOLD_W-1:0];
                    REG_ACTIVE:    active_cnt  = cfg_data[COUNT_W-1:0];
                    default:       ;
                endcase
            end
            fail_count  <= fail_count + errs;
            pending     <= expected_q.size();
            string_busy <= (seq_phase != PH_IDLE);
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// testbench top for the pixel string driver: clock, reset, stimulus and verdict
// depends on wspsd_pkg, ws2812_pixel_string_driver_core and ws2812_pixel_string_checker
module tb;
    import wspsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [PULSE_W-1:0] one_hi;
        logic [PULSE_W-1:0] one_lo;
        logic [PULSE_W-1:0] zero_hi;
        logic [PULSE_W-1:0] zero_lo;
        logic [LATCH_W-1:0] latch;
        logic [HOLD_W-1:0]  hold;
        logic [COUNT_W-1:0] active;
    } wave_cfg_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CMD_W-1:0]      command;
    logic [IDX_W-1:0]      pixel_index;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
    logic                  out_valid;
    logic                  out_ready;
    logic                  line_level;
    logic                  busy_res;
    logic                  accepted;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;
    logic        string_busy;

    int          gap_max = 7;
    int unsigned items_sent;
    int unsigned settings_used;
    int unsigned cycle_cnt;
    wave_cfg_t   cur_cfg;

    ws2812_pixel_string_driver_core #(
        .MAX_PIXELS(MAX_PIXELS_DEF)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .pixel_index(pixel_index),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .line_level(line_level),
        .busy_res(busy_res),
        .accepted(accepted),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ws2812_pixel_string_checker #(
        .MAX_PIXELS(MAX_PIXELS_DEF)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .pixel_index(pixel_index),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .line_level(line_level),
        .busy_res(busy_res),
        .accepted(accepted),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending_count),
        .checked(checked_count),
        .string_busy(string_busy)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_count);
        $display("Some tests failed");
        $finish;
    end

    // result side stalls at random before transfers
    initial begin : result_sink
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, gap_max);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic wave_cfg_t make_cfg(input int oh, input int ol, input int zh,
                                           input int zl, input int lt, input int ho,
                                           input int ap);
        wave_cfg_t c;
        c.one_hi  = oh;
        c.one_lo  = ol;
        c.zero_hi = zh;
        c.zero_lo = zl;
        c.latch   = lt;
        c.hold    = ho;
        c.active  = ap;
        return c;
    endfunction

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                        input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                        input logic [COLOR_W-1:0] b);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        pixel_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic tick();
        send(CMD_TICK, $urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255));
    endtask

    task automatic send_noise();
        logic [CMD_W-1:0] cmd;
        case ($urandom_range(0, 2))
            0:       cmd = CMD_SET;
            1:       cmd = CMD_FLUSH;
            default: cmd = CMD_UNUSED;
        endcase
        send(cmd, $urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255));
    endtask

    task automatic set_random_pixel();
        int unsigned eff;
        eff = (cur_cfg.active > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : cur_cfg.active;
        if (eff == 0 || $urandom_range(0, 7) == 0)
            send(CMD_SET, $urandom_range(0, 63), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
        else
            send(CMD_SET, $urandom_range(0, eff - 1), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // tick until the string is idle, with stray commands mixed in (noise 0 means none)
    task automatic run_out(input int noise);
        do begin
            if (noise > 0 && $urandom_range(1, noise) == 1)
                send_noise();
            tick();
        end while (string_busy);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    task automatic write_regs(input wave_cfg_t c, input bit junk_on);
        logic [CFG_IDX_W-1:0]  reg_idx [7];
        logic [CFG_DATA_W-1:0] reg_val [7];
        logic [CFG_DATA_W-1:0] junk;
        settle();
        junk = junk_on ? $urandom : '0;
        reg_idx = '{REG_ONE_HIGH, REG_ONE_LOW, REG_ZERO_HIGH, REG_ZERO_LOW,
                    REG_LATCH, REG_HOLDOFF, REG_ACTIVE};
        reg_val[0] = {junk[CFG_DATA_W-1:PULSE_W], c.one_hi};
        reg_val[1] = {junk[CFG_DATA_W-1:PULSE_W], c.one_lo};
        reg_val[2] = {junk[CFG_DATA_W-1:PULSE_W], c.zero_hi};
        reg_val[3] = {junk[CFG_DATA_W-1:PULSE_W], c.zero_lo};
        reg_val[4] = {junk[CFG_DATA_W-1:LATCH_W], c.latch};
        reg_val[5] = c.hold;
        reg_val[6] = {junk[CFG_DATA_W-1:COUNT_W], c.active};
        for (int k = 0; k < 7; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx[k];
            cfg_data  <= reg_val[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_cfg = c;
        settings_used++;
    endtask

    initial begin : stimulus
        wave_cfg_t   c;
        int unsigned rand_start;
        int          pick;
        in_valid    <= 1'b0;
        command     <= CMD_TICK;
        pixel_index <= '0;
        red         <= '0;
        green       <= '0;
        blue        <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_ONE_HIGH;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        items_sent    = 0;
        settings_used = 1;
        cur_cfg = make_cfg(ONE_HIGH_RST, ONE_LOW_RST, ZERO_HIGH_RST, ZERO_LOW_RST,
                           LATCH_RST, HOLDOFF_RST, ACTIVE_RST);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle tick, unused code, index range edges
        send(CMD_TICK, 6'h3f, 8'hff, 8'hff, 8'hff);
        send(CMD_UNUSED, 6'h00, 8'h00, 8'h00, 8'h00);
        send(CMD_SET, 6'd0, 8'hff, 8'hff, 8'hff);
        send(CMD_SET, 6'd41, 8'h00, 8'h00, 8'h00);
        send(CMD_SET, 6'd42, 8'h12, 8'h34, 8'h56);
        send(CMD_SET, 6'd63, 8'hff, 8'hff, 8'hff);
        send(CMD_SET, 6'd5, 8'h81, 8'h7e, 8'h18);

        // zero pulse, latch and holdoff lengths, one pixel, commands refused while busy
        write_regs(make_cfg(0, 0, 0, 0, 0, 0, 1), 1'b0);
        send(CMD_SET, 6'd1, 8'h55, 8'haa, 8'h55);
        send(CMD_SET, 6'd0, 8'hf0, 8'h0f, 8'ha5);
        send(CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00);
        send(CMD_SET, 6'd0, 8'h00, 8'h00, 8'h00);
        send(CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00);
        send(CMD_UNUSED, 6'h3f, 8'hff, 8'hff, 8'hff);
        run_out(0);

        // no pixels: flush goes straight to the latch gap
        write_regs(make_cfg(2, 1, 1, 2, 3, 2, 0), 1'b0);
        send(CMD_SET, 6'd0, 8'h11, 8'h22, 8'h33);
        send(CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00);
        send(CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00);
        run_out(0);

        // pixel count above the store size is limited to the full store
        write_regs(make_cfg(1, 1, 1, 1, 1, 1, 127), 1'b0);
        send(CMD_SET, 6'd63, 8'h00, 8'hff, 8'h0f);
        send(CMD_SET, 6'd32, 8'hc3, 8'h3c, 8'h99);
        send(CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00);
        run_out(16);

        // longest pulses and latch, sent back to back
        gap_max = 0;
        write_regs(make_cfg(1023, 1023, 1023, 1023, 65535, 5, 1), 1'b0);
        send(CMD_SET, 6'd0, 8'ha5, 8'h5a, 8'h3c);
        send(CMD_FLUSH, 6'd0, 8'h00, 8'h00, 8'h00);
        run_out(0);
        gap_max = 7;

        // longest holdoff written, random pixels and the last pixel set, no flush
        write_regs(make_cfg(1023, 1, 1023, 1, 65535, 16777215, 64), 1'b0);
        repeat (12) set_random_pixel();
        send(CMD_SET, 6'd63, 8'h01, 8'h02, 8'h03);
        send(CMD_UNUSED, 6'd10, 8'h00, 8'h00, 8'h00);
        repeat (4) tick();

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            c = make_cfg($urandom_range(0, ($urandom_range(0, 4) == 0) ? 8 : 2),
                         $urandom_range(0, ($urandom_range(0, 4) == 0) ? 8 : 2),
                         $urandom_range(0, ($urandom_range(0, 4) == 0) ? 8 : 2),
                         $urandom_range(0, ($urandom_range(0, 4) == 0) ? 8 : 2),
                         $urandom_range(0, 6), $urandom_range(0, 6),
                         (pick == 0) ? 0 : ((pick < 7) ? 1 : 2));
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            write_regs(c, $urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(1, 5)) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        set_random_pixel();
                    else if (pick == 6)
                        tick();
                    else
                        send($urandom_range(0, 3), $urandom_range(0, 63),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
                end
                send(CMD_FLUSH, $urandom_range(0, 63), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
                run_out(8);
            end
        end

        settle();
        repeat (16) @(posedge clk);
        $display("covered %0d register settings, %0d command transfers, %0d results checked",
                 settings_used, items_sent, checked_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
